// ----- design/wrc_pkg.sv -----
// Package for the write request coalescer: widths, status codes, register
// indexes and shared structs. No dependencies.
package wrc_pkg;
    localparam int MaxRequests = 16;
    localparam int IdxW = $clog2(MaxRequests);
    localparam int CntW = $clog2(MaxRequests + 1);

    localparam logic [2:0] ST_MERGE = 3'd0;
    localparam logic [2:0] ST_EXTEND = 3'd1;
    localparam logic [2:0] ST_APPEND = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;
    localparam logic [2:0] ST_EMPTY = 3'd5;

    localparam logic CFG_TXN_ID = 1'b0;
    localparam logic CFG_SCALE = 1'b1;

    localparam logic [31:0] M32 = 32'hFFFF_FFFF;
    localparam logic [35:0] M36 = 36'hF_FFFF_FFFF;
    localparam logic [37:0] M38 = 38'h3F_FFFF_FFFF;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input request
        logic scan;     // compare entry at scan index
        logic update;   // apply enqueue outcome
        logic fl_read;  // read entry for flush
        logic fl_mul;   // scale read entry
        logic emit;     // load output register
        logic clear;    // clear table after flush
    } wrc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_flush;
        logic scan_done;
        logic empty;
        logic fl_last;
    } wrc_sts_t;
endpackage

// ----- design/wrc_datapath.sv -----
// Datapath of the write request coalescer: entry table, scan compare,
// flush scaling and output register. Depends on wrc_pkg.
module wrc_datapath
    import wrc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  wrc_cmd_t     cmd,
    output wrc_sts_t     sts,
    input  logic [128:0] in_data,
    input  logic [15:0]  txn_id,
    input  logic [6:0]   scale,
    output logic [184:0] out_data,
    output logic         out_last
);
    // request fields
    logic        act_reg;
    logic [31:0] h_reg, so_reg, do_reg;
    logic [15:0] n_reg, bid_reg;
    // table
    logic [31:0] th [MaxRequests];
    logic [31:0] ts [MaxRequests];
    logic [31:0] td [MaxRequests];
    logic [31:0] tl [MaxRequests];
    logic [CntW-1:0] cnt_reg;
    logic [35:0] tot_reg;
    logic [CntW-1:0] idx_reg;
    logic [2:0] res_reg;      // outcome of scan
    logic [IdxW-1:0] hit_reg;
    logic found_reg;
    logic [31:0] rs_reg, rd_reg, rl_reg;
    logic [38:0] ps_reg, pd_reg, pl_reg;
    logic last_reg;

    logic [IdxW-1:0] idx;
    logic match, same, cont;
    logic [32:0] es, ed, nl;
    logic [31:0] lnew, ecur;
    logic [35:0] delta;
    logic [36:0] tsum;

    assign idx = idx_reg[IdxW-1:0];
    assign es = {1'b0, ts[idx]} + {1'b0, tl[idx]};
    assign ed = {1'b0, td[idx]} + {1'b0, tl[idx]};
    assign match = (idx_reg < cnt_reg) && (th[idx] == h_reg);
    assign same = match && (ts[idx] == so_reg);
    assign cont = match && !same && (es == {1'b0, so_reg}) && (ed == {1'b0, do_reg});

    assign sts.is_flush = act_reg;
    assign sts.scan_done = found_reg || (idx_reg >= cnt_reg);
    assign sts.empty = (cnt_reg == '0);
    assign sts.fl_last = (idx_reg + 1'b1 == cnt_reg);

    // enqueue update arithmetic
    assign ecur = tl[hit_reg];
    assign nl = {1'b0, ecur} + {17'd0, n_reg};
    always_comb begin
        lnew = ecur;
        delta = '0;
        case (res_reg)
            ST_MERGE: if ({16'd0, n_reg} > ecur) begin
                lnew = {16'd0, n_reg};
                delta = {4'd0, lnew - ecur};
            end
            ST_EXTEND: begin
                lnew = nl[32] ? M32 : nl[31:0];
                delta = {4'd0, lnew - ecur};
            end
            ST_APPEND: delta = {20'd0, n_reg};
            default: delta = '0;
        endcase
    end
    assign tsum = {1'b0, tot_reg} + {1'b0, delta};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            tot_reg <= '0;
            idx_reg <= '0;
            found_reg <= 1'b0;
            act_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                act_reg <= in_data[0];
                h_reg <= in_data[32:1];
                so_reg <= in_data[64:33];
                do_reg <= in_data[96:65];
                n_reg <= in_data[112:97];
                bid_reg <= in_data[128:113];
                idx_reg <= '0;
                found_reg <= 1'b0;
                res_reg <= ST_APPEND;
            end
            // one entry compared per cycle
            if (cmd.scan && !found_reg && idx_reg < cnt_reg) begin
                if (same || cont) begin
                    found_reg <= 1'b1;
                    hit_reg <= idx;
                    res_reg <= same ? ST_MERGE : ST_EXTEND;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (cmd.update) begin
                if (found_reg) begin
                    tl[hit_reg] <= lnew;
                    tot_reg <= tsum[36] || tsum[35:0] > M36 ? M36 : tsum[35:0];
                end else if (cnt_reg >= CntW'(MaxRequests)) begin
                    res_reg <= ST_FULL;
                end else begin
                    th[cnt_reg[IdxW-1:0]] <= h_reg;
                    ts[cnt_reg[IdxW-1:0]] <= so_reg;
                    td[cnt_reg[IdxW-1:0]] <= do_reg;
                    tl[cnt_reg[IdxW-1:0]] <= {16'd0, n_reg};
                    cnt_reg <= cnt_reg + 1'b1;
                    tot_reg <= tsum[36] ? M36 : tsum[35:0];
                end
            end
            if (cmd.fl_read) begin
                rs_reg <= ts[idx];
                rd_reg <= td[idx];
                rl_reg <= tl[idx];
                last_reg <= sts.fl_last;
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.clear) begin
                cnt_reg <= '0;
                tot_reg <= '0;
            end
        end
        if (cmd.fl_mul) begin
            ps_reg <= 39'(rs_reg) * 39'(scale);
            pd_reg <= 39'(rd_reg) * 39'(scale);
            pl_reg <= 39'(rl_reg) * 39'(scale);
        end
    end

    // output register: status in the low bits, then ids, offsets, length, total
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if (!act_reg) begin
                out_data <= {tot_reg, 38'd0, 38'd0, 38'd0, 16'd0, 16'd0, res_reg};
                out_last <= 1'b1;
            end else if (cnt_reg == '0) begin
                out_data <= {tot_reg, 38'd0, 38'd0, 38'd0, txn_id, bid_reg, ST_EMPTY};
                out_last <= 1'b1;
            end else begin
                out_data <= {tot_reg,
                             pl_reg[38] ? M38 : pl_reg[37:0],
                             pd_reg[38] ? M38 : pd_reg[37:0],
                             ps_reg[38] ? M38 : ps_reg[37:0],
                             txn_id, bid_reg, ST_FLUSH};
                out_last <= last_reg;
            end
        end
    end

    // appended entries never exceed the table
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CntW'(MaxRequests)) else $error("entry count overflow");
    // clear empties table next cycle
    a_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> cnt_reg == '0) else $error("clear failed");
    // a request dropped on a full table leaves the count alone
    a_tot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update && !found_reg && cnt_reg >= CntW'(MaxRequests) |=> $stable(cnt_reg))
        else $error("full table changed");
endmodule

// ----- design/wrc_ctrl.sv -----
// Controller of the write request coalescer: sequences scan, update and
// flush emission. Depends on wrc_pkg.
module wrc_ctrl
    import wrc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output wrc_cmd_t cmd,
    input  wrc_sts_t sts
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic vld_reg, vld_next, last_reg, last_next;
    logic room;

    // output register frees when empty or taken this cycle
    assign room = !vld_reg || m_tready;
    assign m_tvalid = vld_reg;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        vld_next = vld_reg && !m_tready;
        last_next = last_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) begin
                cmd.load = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (sts.is_flush) begin
                    state_next = sts.empty ? S_EMIT : S_RD;
                    last_next = sts.empty;
                end else if (sts.scan_done) begin
                    state_next = S_UPD;
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            S_UPD: begin
                cmd.update = 1'b1;
                last_next = 1'b1;
                state_next = S_EMIT;
            end
            S_RD: begin
                cmd.fl_read = 1'b1;
                last_next = sts.fl_last;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.fl_mul = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: if (room) begin
                cmd.emit = 1'b1;
                vld_next = 1'b1;
                if (sts.is_flush && last_reg) cmd.clear = 1'b1;
                state_next = (sts.is_flush && !last_reg) ? S_RD : S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            vld_reg <= 1'b0;
            last_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            vld_reg <= vld_next;
            last_reg <= last_next;
        end
    end

    a_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> room) else $error("emit over pending result");
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == S_SCAN) else $error("bad load step");
    a_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> cmd.emit) else $error("clear without emit");
endmodule

// ----- design/write_request_coalescer_top.sv -----
// Top level of the write request coalescer: joins controller, datapath and
// the configuration registers. Depends on wrc_pkg, wrc_ctrl, wrc_datapath.
// s_tuser selects enqueue (0) or flush (1) of the request on s_tdata; status
// travels on m_tuser and m_tlast marks the final result of a request. An
// enqueue compares the stored table entries in turn (up to 16, one compare
// per cycle) until one matches or all are compared, then updates the table
// and loads the result. A flush reads, scale multiplies and loads the output
// for each stored entry in turn, or loads one empty-status result when the
// table is empty. One request is handled at a time; the result register lets
// the next request start while the last result waits on m_tready, and a
// further result stalls until that register is taken.
module write_request_coalescer_top
    import wrc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // buffer_handle, src_offset, device_ofs, block_count_in, flush_buffer_id
    input  logic [127:0] s_tdata,
    // action
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_buffer_id, out_txn_id, out_src_offset, out_device_ofs, out_length,
    // total_blocks, zero pad
    output logic [183:0] m_tdata,
    // status
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);
    wrc_cmd_t cmd;
    wrc_sts_t sts;
    logic [15:0] txn_reg;
    logic [6:0]  scale_reg;
    logic [184:0] dp_out;

    assign cfg_ready = 1'b1;
    assign m_tuser = dp_out[2:0];
    assign m_tdata = {2'b00, dp_out[184:3]};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            txn_reg <= '0;
            scale_reg <= 7'd16;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TXN_ID: txn_reg <= cfg_data;
                CFG_SCALE:  scale_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    wrc_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
        .cmd, .sts
    );

    wrc_datapath u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .in_data({s_tdata, s_tuser}),
        .txn_id(txn_reg), .scale(scale_reg),
        .out_data(dp_out), .out_last(m_tlast)
    );
endmodule
